@@ hw/rtl/sdci_pkg.sv @@
// Shared types and constants of the SD/eMMC card bring-up sequencer.
package sdci_pkg;

	// Sequencer phases
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_GOIDLE = 4'd1;
	localparam logic [3:0] PH_IFCOND = 4'd2;
	localparam logic [3:0] PH_APP    = 4'd3;
	localparam logic [3:0] PH_ACMD41 = 4'd4;
	localparam logic [3:0] PH_OPCOND = 4'd5;
	localparam logic [3:0] PH_CID    = 4'd6;
	localparam logic [3:0] PH_RCA    = 4'd7;
	localparam logic [3:0] PH_CSD    = 4'd8;
	localparam logic [3:0] PH_SELECT = 4'd9;
	localparam logic [3:0] PH_BLKLEN = 4'd10;
	localparam logic [3:0] PH_READY  = 4'd11;
	localparam logic [3:0] PH_FAILED = 4'd12;
	localparam logic [3:0] PH_NEVER  = 4'd13;

	// Response types
	localparam logic [1:0] RSP_NONE = 2'd0;
	localparam logic [1:0] RSP_136  = 2'd1;
	localparam logic [1:0] RSP_48   = 2'd2;
	localparam logic [1:0] RSP_48B  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_READY  = 2'd1;
	localparam logic [1:0] ST_FAILED = 2'd2;
	localparam logic [1:0] ST_NEVER  = 2'd3;

	// Input actions
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_OUTCOME = 1'b1;

	// Command indexes
	localparam logic [5:0] CMD_RESET_CARD = 6'd0;
	localparam logic [5:0] CMD_SEND_OP    = 6'd1;
	localparam logic [5:0] CMD_ALL_CID    = 6'd2;
	localparam logic [5:0] CMD_REL_ADDR   = 6'd3;
	localparam logic [5:0] CMD_PICK_CARD  = 6'd7;
	localparam logic [5:0] CMD_IF_COND    = 6'd8;
	localparam logic [5:0] CMD_GET_CSD    = 6'd9;
	localparam logic [5:0] CMD_BLOCK_LEN  = 6'd16;
	localparam logic [5:0] ACMD_SD_OP     = 6'd41;
	localparam logic [5:0] CMD_APP        = 6'd55;

	// Arguments and masks
	localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
	localparam logic [7:0]  IF_COND_ECHO  = 8'hAA;
	localparam logic [31:0] ARG_SD_VOLT   = 32'h00FF_8000;
	localparam logic [31:0] ARG_SD_HCS    = 32'h4000_0000;
	localparam logic [31:0] ARG_EMMC_OP   = 32'h40FF_8000;
	localparam logic [31:0] ARG_BLOCK_LEN = 32'd512;
	localparam logic [15:0] EMMC_RCA      = 16'd1;
	localparam logic [11:0] TRIES_RESET   = 12'd2000;

	typedef struct packed {
		logic        action;
		logic        cmd_ok;
		logic [31:0] resp_word0;
		logic [31:0] resp_word1;
		logic [31:0] resp_word2;
		logic [31:0] resp_word3;
	} sdci_in_t;

	typedef struct packed {
		logic        issue;
		logic [13:0] cmd_word;
		logic [31:0] cmd_arg;
		logic        wait_data_free;
		logic [1:0]  status;
		logic        block_mode;
		logic        emmc_card;
		logic [15:0] card_address;
		logic [32:0] capacity_blocks;
	} sdci_out_t;

endpackage

@@ hw/rtl/sdci_chan_if.sv @@
// Valid/ready channels for command outcomes and issued commands.
interface sdci_outcome_if import sdci_pkg::*; ();
	logic     valid;
	logic     ready;
	sdci_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdci_command_if import sdci_pkg::*; ();
	logic      valid;
	logic      ready;
	sdci_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/sdci_csd_decode.sv @@
// CSD capacity decoder: card size in 512-byte blocks for CSD version 1 and 2.
module sdci_csd_decode import sdci_pkg::*; (
	input  logic [31:0] csd_word0,
	input  logic [31:0] csd_word1,
	input  logic [31:0] csd_word2,
	input  logic [31:0] csd_word3,
	output logic [32:0] size_blocks
);

	logic [22:0] c_v2;
	logic [12:0] c_v1;
	logic [4:0]  shamt;
	logic [36:0] bytes_v1;

	// Version 2: (C_SIZE + 1) * 1024 blocks
	assign c_v2 = 23'(csd_word1[29:8]) + 23'd1;

	// Version 1: (C_SIZE + 1) << (C_SIZE_MULT + 2 + block length exponent) bytes
	assign c_v1     = 13'({csd_word2[1:0], csd_word1[31:22]}) + 13'd1;
	assign shamt    = 5'({csd_word1[1:0], csd_word0[31]}) + 5'd2 + 5'(csd_word2[11:8]);
	assign bytes_v1 = 37'(c_v1) << shamt;

	// Pick by CSD structure; any nonzero structure decodes as version 2
	always_comb begin
		if (csd_word3[23:22] != 2'd0) begin
			size_blocks = {c_v2, 10'd0};
		end else begin
			size_blocks = 33'(bytes_v1[36:9]);
		end
	end

endmodule

@@ hw/rtl/sd_emmc_card_init_sequencer.sv @@
// Top level: SD/eMMC card bring-up sequencer, outcome in, next command out.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the command side takes results; the whole phase step is one combinational pass.
// A stalled result holds in the result register while one more item waits in the input register.
// Reset: phase idle, card record cleared, op_cond_tries back to 2000, both registers empty.
module sd_emmc_card_init_sequencer import sdci_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [11:0]  cfg_wr_data,
	sdci_outcome_if.sink   outcome,
	sdci_command_if.source command
);

	// Config and state registers
	logic [11:0] tries_q;
	logic [3:0]  phase_q;
	logic        emmc_q;
	logic        spec_v2_q;
	logic [11:0] attempt_q;
	logic        block_q;
	logic [15:0] rca_q;
	logic [32:0] size_q;

	// Input and result registers
	logic        valid_s1;
	sdci_in_t    item_s1;
	logic        out_valid_q;
	sdci_out_t   out_q;

	// Next values
	logic [3:0]  phase_d;
	logic        emmc_d;
	logic        spec_v2_d;
	logic [11:0] attempt_d;
	logic        block_d;
	logic [15:0] rca_d;
	logic [32:0] size_d;
	logic        issue_d;
	logic [5:0]  idx_d;
	logic [31:0] arg_d;
	logic [1:0]  rsp_d;
	logic        ichk_d;
	logic        op_try;
	logic [1:0]  status_d;
	logic [32:0] csd_size;
	sdci_out_t   result_d;
	logic        adv;

	// Advance the input register into the result register when the slot is free
	assign adv           = valid_s1 && (!out_valid_q || command.ready);
	assign outcome.ready = !valid_s1 || adv;

	sdci_csd_decode u_csd (
		.csd_word0   (item_s1.resp_word0),
		.csd_word1   (item_s1.resp_word1),
		.csd_word2   (item_s1.resp_word2),
		.csd_word3   (item_s1.resp_word3),
		.size_blocks (csd_size)
	);

	// Phase step
	always_comb begin
		phase_d   = phase_q;
		emmc_d    = emmc_q;
		spec_v2_d = spec_v2_q;
		attempt_d = attempt_q;
		block_d   = block_q;
		rca_d     = rca_q;
		size_d    = size_q;
		issue_d   = 1'b0;
		idx_d     = CMD_RESET_CARD;
		arg_d     = 32'd0;
		rsp_d     = RSP_NONE;
		ichk_d    = 1'b0;
		op_try    = 1'b0;

		if (item_s1.action == ACT_START) begin
			emmc_d    = 1'b0;
			spec_v2_d = 1'b0;
			attempt_d = 12'd0;
			block_d   = 1'b0;
			rca_d     = 16'd0;
			size_d    = 33'd0;
			issue_d   = 1'b1;
			phase_d   = PH_GOIDLE;
		end else begin
			case (phase_q)
				PH_GOIDLE: begin
					issue_d = 1'b1;
					idx_d   = CMD_IF_COND;
					arg_d   = ARG_IF_COND;
					rsp_d   = RSP_48;
					ichk_d  = 1'b1;
					phase_d = PH_IFCOND;
				end
				PH_IFCOND: begin
					spec_v2_d = item_s1.cmd_ok && (item_s1.resp_word0[7:0] == IF_COND_ECHO);
					attempt_d = 12'd0;
					op_try    = 1'b1;
				end
				PH_APP, PH_ACMD41, PH_OPCOND: begin
					if (!item_s1.cmd_ok) begin
						// First SD failure falls back to eMMC; others fail
						if (phase_q != PH_OPCOND && attempt_q == 12'd0) begin
							emmc_d    = 1'b1;
							attempt_d = 12'd1;
							op_try    = 1'b1;
						end else begin
							phase_d = PH_FAILED;
						end
					end else if (phase_q == PH_APP) begin
						issue_d = 1'b1;
						idx_d   = ACMD_SD_OP;
						arg_d   = (spec_v2_q ? ARG_SD_HCS : 32'd0) | ARG_SD_VOLT;
						rsp_d   = RSP_48;
						phase_d = PH_ACMD41;
					end else if (item_s1.resp_word0[31]) begin
						block_d = item_s1.resp_word0[30];
						issue_d = 1'b1;
						idx_d   = CMD_ALL_CID;
						rsp_d   = RSP_136;
						phase_d = PH_CID;
					end else begin
						attempt_d = attempt_q + 12'd1;
						op_try    = 1'b1;
					end
				end
				PH_CID: begin
					if (!item_s1.cmd_ok) begin
						phase_d = PH_FAILED;
					end else begin
						if (emmc_q) begin
							rca_d = EMMC_RCA;
							arg_d = {EMMC_RCA, 16'd0};
						end
						issue_d = 1'b1;
						idx_d   = CMD_REL_ADDR;
						rsp_d   = RSP_48;
						ichk_d  = 1'b1;
						phase_d = PH_RCA;
					end
				end
				PH_RCA: begin
					if (!item_s1.cmd_ok) begin
						phase_d = PH_FAILED;
					end else begin
						if (!emmc_q) begin
							rca_d = item_s1.resp_word0[31:16];
						end
						issue_d = 1'b1;
						idx_d   = CMD_GET_CSD;
						arg_d   = {rca_d, 16'd0};
						rsp_d   = RSP_136;
						phase_d = PH_CSD;
					end
				end
				PH_CSD: begin
					if (!item_s1.cmd_ok) begin
						phase_d = PH_FAILED;
					end else begin
						size_d  = csd_size;
						issue_d = 1'b1;
						idx_d   = CMD_PICK_CARD;
						arg_d   = {rca_q, 16'd0};
						rsp_d   = RSP_48B;
						ichk_d  = 1'b1;
						phase_d = PH_SELECT;
					end
				end
				PH_SELECT: begin
					if (!item_s1.cmd_ok) begin
						phase_d = PH_FAILED;
					end else if (!block_q) begin
						issue_d = 1'b1;
						idx_d   = CMD_BLOCK_LEN;
						arg_d   = ARG_BLOCK_LEN;
						rsp_d   = RSP_48;
						ichk_d  = 1'b1;
						phase_d = PH_BLKLEN;
					end else begin
						phase_d = PH_READY;
					end
				end
				PH_BLKLEN: begin
					phase_d = item_s1.cmd_ok ? PH_READY : PH_FAILED;
				end
				default: begin
				end
			endcase

			// Start the next op-cond attempt, or give up when tries run out
			if (op_try) begin
				if (attempt_d >= tries_q) begin
					phase_d = PH_NEVER;
				end else if (emmc_d) begin
					issue_d = 1'b1;
					idx_d   = CMD_SEND_OP;
					arg_d   = ARG_EMMC_OP;
					rsp_d   = RSP_48;
					phase_d = PH_OPCOND;
				end else begin
					issue_d = 1'b1;
					idx_d   = CMD_APP;
					arg_d   = 32'd0;
					rsp_d   = RSP_48;
					ichk_d  = 1'b1;
					phase_d = PH_APP;
				end
			end
		end
	end

	// Status from the new phase
	always_comb begin
		case (phase_d)
			PH_READY:  status_d = ST_READY;
			PH_FAILED: status_d = ST_FAILED;
			PH_NEVER:  status_d = ST_NEVER;
			default:   status_d = ST_BUSY;
		endcase
	end

	// Build the result item
	always_comb begin
		result_d.issue           = issue_d;
		result_d.cmd_word        = {idx_d, 3'd0, ichk_d, (rsp_d != RSP_NONE), 1'b0, rsp_d};
		result_d.cmd_arg         = arg_d;
		result_d.wait_data_free  = (rsp_d == RSP_48B);
		result_d.status          = status_d;
		result_d.block_mode      = block_d;
		result_d.emmc_card       = emmc_d;
		result_d.card_address    = rca_d;
		result_d.capacity_blocks = size_d;
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tries_q <= TRIES_RESET;
		end else if (cfg_wr_en) begin
			tries_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (outcome.ready) begin
			valid_s1 <= outcome.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (outcome.valid && outcome.ready) begin
			item_s1 <= outcome.data;
		end
	end

	// Sequencer state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			emmc_q      <= 1'b0;
			spec_v2_q   <= 1'b0;
			attempt_q   <= 12'd0;
			block_q     <= 1'b0;
			rca_q       <= 16'd0;
			size_q      <= 33'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q   <= phase_d;
				emmc_q    <= emmc_d;
				spec_v2_q <= spec_v2_d;
				attempt_q <= attempt_d;
				block_q   <= block_d;
				rca_q     <= rca_d;
				size_q    <= size_d;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (command.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result_d;
		end
	end

	assign command.valid = out_valid_q;
	assign command.data  = out_q;

	// A start item always leaves the sequencer waiting on CMD0 with a clean record
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.action == ACT_START |=>
		phase_q == PH_GOIDLE && attempt_q == 12'd0 && !emmc_q && size_q == 33'd0)
		else $error("start item did not reset the sequence");

	// CMD1 polling only happens for a card taken as eMMC
	a_opcond_emmc: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OPCOND |-> emmc_q)
		else $error("CMD1 phase without eMMC flag");

	// A waiting item is never dropped while the result side is stalled
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input register lost its item");

	// Only the select command waits for the data line
	a_busy_is_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.wait_data_free |->
		out_q.issue && out_q.cmd_word[13:8] == CMD_PICK_CARD)
		else $error("busy wait on a command other than select");

endmodule

@@ bench/sd_emmc_card_init_sequencer_test.sv @@
// Self-checking testbench of the SD/eMMC card bring-up sequencer.
module sd_emmc_card_init_sequencer_test import sdci_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD = 120;
	localparam logic [31:0] ONES = 32'hFFFF_FFFF;
	localparam sdci_out_t GO_IDLE_ISSUED = '{issue: 1'b1, default: '0};

	typedef struct {
		sdci_in_t  item;
		bit        typed;
		sdci_out_t result;
	} step_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [11:0] cfg_wr_data;

	sdci_outcome_if outcome_ch();
	sdci_command_if command_ch();

	sd_emmc_card_init_sequencer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.outcome     (outcome_ch),
		.command     (command_ch)
	);

	// Predicted sequencer state and card record
	logic [11:0] tries_cfg;
	logic [3:0]  card_phase;
	logic        emmc_seen;
	logic        v2_card;
	logic [11:0] attempts;
	logic        block_addr;
	logic [15:0] rca_value;
	logic [32:0] blocks_total;

	sdci_out_t   expected_cmds[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit          long_stall_request;

	always #1 clk = ~clk;

	// Build the command word, argument and busy wait of one issued command
	function automatic sdci_out_t command_of(logic [5:0] idx, logic [31:0] arg,
			logic [1:0] rsp, logic idx_check);
		sdci_out_t c;
		c = '0;
		c.issue = 1'b1;
		c.cmd_word = {idx, 3'b000, idx_check, rsp != RSP_NONE, 1'b0, rsp};
		c.cmd_arg = arg;
		c.wait_data_free = (rsp == RSP_48B);
		return c;
	endfunction

	// Issue the next operating-condition attempt, or give up when out of tries
	function automatic sdci_out_t try_op_cond();
		if (attempts >= tries_cfg) begin
			card_phase = PH_NEVER;
			return '0;
		end else if (emmc_seen) begin
			card_phase = PH_OPCOND;
			return command_of(CMD_SEND_OP, ARG_EMMC_OP, RSP_48, 1'b0);
		end
		card_phase = PH_APP;
		return command_of(CMD_APP, '0, RSP_48, 1'b1);
	endfunction

	// A failed SD attempt: fall back to eMMC on the first try, else fail
	function automatic sdci_out_t sd_op_failed();
		if (attempts == '0) begin
			emmc_seen = 1'b1;
			attempts = 12'd1;
			return try_op_cond();
		end
		card_phase = PH_FAILED;
		return '0;
	endfunction

	// Step the predicted sequencer by one item and return the command it yields
	function automatic sdci_out_t next_command(sdci_in_t it);
		sdci_out_t   r;
		logic [63:0] c_size;
		int unsigned shift;
		r = '0;
		if (it.action == ACT_START) begin
			emmc_seen = 1'b0;
			v2_card = 1'b0;
			attempts = '0;
			block_addr = 1'b0;
			rca_value = '0;
			blocks_total = '0;
			r = command_of(CMD_RESET_CARD, '0, RSP_NONE, 1'b0);
			card_phase = PH_GOIDLE;
		end else begin
			case (card_phase)
				PH_GOIDLE: begin
					r = command_of(CMD_IF_COND, ARG_IF_COND, RSP_48, 1'b1);
					card_phase = PH_IFCOND;
				end
				PH_IFCOND: begin
					v2_card = it.cmd_ok && (it.resp_word0[7:0] == IF_COND_ECHO);
					attempts = '0;
					r = try_op_cond();
				end
				PH_APP: begin
					if (it.cmd_ok) begin
						r = command_of(ACMD_SD_OP,
							(v2_card ? ARG_SD_HCS : 32'h0) | ARG_SD_VOLT, RSP_48, 1'b0);
						card_phase = PH_ACMD41;
					end else begin
						r = sd_op_failed();
					end
				end
				PH_ACMD41, PH_OPCOND: begin
					if (!it.cmd_ok) begin
						if (card_phase == PH_ACMD41) begin
							r = sd_op_failed();
						end else begin
							card_phase = PH_FAILED;
						end
					end else if (it.resp_word0[31]) begin
						block_addr = it.resp_word0[30];
						r = command_of(CMD_ALL_CID, '0, RSP_136, 1'b0);
						card_phase = PH_CID;
					end else begin
						attempts = attempts + 12'd1;
						r = try_op_cond();
					end
				end
				PH_CID: begin
					if (!it.cmd_ok) begin
						card_phase = PH_FAILED;
					end else begin
						if (emmc_seen) begin
							rca_value = EMMC_RCA;
						end
						r = command_of(CMD_REL_ADDR, emmc_seen ? {EMMC_RCA, 16'h0} : 32'h0,
							RSP_48, 1'b1);
						card_phase = PH_RCA;
					end
				end
				PH_RCA: begin
					if (!it.cmd_ok) begin
						card_phase = PH_FAILED;
					end else begin
						if (!emmc_seen) begin
							rca_value = it.resp_word0[31:16];
						end
						r = command_of(CMD_GET_CSD, {rca_value, 16'h0}, RSP_136, 1'b0);
						card_phase = PH_CSD;
					end
				end
				PH_CSD: begin
					if (!it.cmd_ok) begin
						card_phase = PH_FAILED;
					end else begin
						// Decode capacity: version 2 counts 512 KiB units, version 1 bytes
						if (it.resp_word3[23:22] != 2'd0) begin
							c_size = 64'(it.resp_word1[29:8]) + 64'd1;
							blocks_total = 33'(c_size << 10);
						end else begin
							c_size = 64'({it.resp_word2[1:0], it.resp_word1[31:22]}) + 64'd1;
							shift = int'({it.resp_word1[1:0], it.resp_word0[31]}) + 2
								+ int'(it.resp_word2[11:8]);
							blocks_total = 33'((c_size << shift) >> 9);
						end
						r = command_of(CMD_PICK_CARD, {rca_value, 16'h0}, RSP_48B, 1'b1);
						card_phase = PH_SELECT;
					end
				end
				PH_SELECT: begin
					if (!it.cmd_ok) begin
						card_phase = PH_FAILED;
					end else if (!block_addr) begin
						r = command_of(CMD_BLOCK_LEN, ARG_BLOCK_LEN, RSP_48, 1'b1);
						card_phase = PH_BLKLEN;
					end else begin
						card_phase = PH_READY;
					end
				end
				PH_BLKLEN: card_phase = it.cmd_ok ? PH_READY : PH_FAILED;
				default: ;
			endcase
		end
		case (card_phase)
			PH_READY:  r.status = ST_READY;
			PH_FAILED: r.status = ST_FAILED;
			PH_NEVER:  r.status = ST_NEVER;
			default:   r.status = ST_BUSY;
		endcase
		r.block_mode = block_addr;
		r.emmc_card = emmc_seen;
		r.card_address = rca_value;
		r.capacity_blocks = blocks_total;
		return r;
	endfunction

	// Random outcome shaped by the predicted phase so sessions run deep
	function automatic sdci_in_t make_item();
		sdci_in_t it;
		it.action = ACT_OUTCOME;
		it.cmd_ok = ($urandom_range(99) < 93);
		it.resp_word0 = $urandom();
		it.resp_word1 = $urandom();
		it.resp_word2 = $urandom();
		it.resp_word3 = $urandom();
		case (card_phase)
			PH_IDLE, PH_READY, PH_FAILED, PH_NEVER: begin
				if ($urandom_range(99) < 85) begin
					it.action = ACT_START;
				end
			end
			PH_IFCOND: begin
				if ($urandom_range(99) < 75) begin
					it.resp_word0[7:0] = IF_COND_ECHO;
				end
			end
			PH_ACMD41, PH_OPCOND: it.resp_word0[31] = ($urandom_range(99) < 35);
			default: ;
		endcase
		// Break a sequence now and then with a restart
		if ($urandom_range(99) < 2) begin
			it.action = ACT_START;
		end
		return it;
	endfunction

	function automatic step_row_t row(logic act, logic ok, logic [31:0] w0, logic [31:0] w1,
			logic [31:0] w2, logic [31:0] w3, bit typed = 1'b0, sdci_out_t lit = '0);
		step_row_t s;
		s.item = '{action: act, cmd_ok: ok, resp_word0: w0, resp_word1: w1,
			resp_word2: w2, resp_word3: w3};
		s.typed = typed;
		s.result = lit;
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	// Offer one item; hold valid high once raised, record the expectation on accept
	task automatic offer(sdci_in_t it, bit typed, sdci_out_t lit);
		sdci_out_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			outcome_ch.valid <= 1'b0;
			@(posedge clk);
		end
		outcome_ch.valid <= 1'b1;
		outcome_ch.data <= it;
		do @(posedge clk); while (!outcome_ch.ready);
		predicted = next_command(it);
		expected_cmds.push_back(typed ? lit : predicted);
	endtask

	// Drop valid and let every outstanding command come out
	task automatic drain();
		outcome_ch.valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tries(logic [11:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tries_cfg = value;
	endtask

	task automatic run_random(int count);
		repeat (count) offer(make_item(), 1'b0, '0);
	endtask

	// Receive commands, check them in order, stall at random or on request
	initial begin
		int unsigned hold_left;
		sdci_out_t   got;
		sdci_out_t   want;
		hold_left = 0;
		command_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (command_ch.valid && command_ch.ready) begin
				got = command_ch.data;
				if (expected_cmds.size() == 0) begin
					report_mismatch("result with nothing expected, cmd_arg",
						64'(got.cmd_arg), '0);
				end else begin
					want = expected_cmds.pop_front();
					if (got.issue !== want.issue)
						report_mismatch("issue", 64'(got.issue), 64'(want.issue));
					if (got.cmd_word !== want.cmd_word)
						report_mismatch("cmd_word", 64'(got.cmd_word), 64'(want.cmd_word));
					if (got.cmd_arg !== want.cmd_arg)
						report_mismatch("cmd_arg", 64'(got.cmd_arg), 64'(want.cmd_arg));
					if (got.wait_data_free !== want.wait_data_free)
						report_mismatch("wait_data_free", 64'(got.wait_data_free),
							64'(want.wait_data_free));
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.block_mode !== want.block_mode)
						report_mismatch("block_mode", 64'(got.block_mode),
							64'(want.block_mode));
					if (got.emmc_card !== want.emmc_card)
						report_mismatch("emmc_card", 64'(got.emmc_card), 64'(want.emmc_card));
					if (got.card_address !== want.card_address)
						report_mismatch("card_address", 64'(got.card_address),
							64'(want.card_address));
					if (got.capacity_blocks !== want.capacity_blocks)
						report_mismatch("capacity_blocks", 64'(got.capacity_blocks),
							64'(want.capacity_blocks));
				end
			end
			if (long_stall_request) begin
				long_stall_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				command_ch.ready <= 1'b0;
			end else begin
				command_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((outcome_ch.valid && outcome_ch.ready) || (command_ch.valid && command_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		step_row_t bring_up_rows[$];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		outcome_ch.valid = 1'b0;
		outcome_ch.data = '0;
		mismatches = 0;
		long_stall_request = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 82;

		tries_cfg = TRIES_RESET;
		card_phase = PH_IDLE;
		emmc_seen = 1'b0;
		v2_card = 1'b0;
		attempts = '0;
		block_addr = 1'b0;
		rca_value = '0;
		blocks_total = '0;

		// Outcome while idle, then an SD v2 block-mode card up to ready
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, ONES, ONES, ONES, ONES, 1'b1, '0));
		bring_up_rows.push_back(row(ACT_START, 1'b0, '0, '0, '0, '0, 1'b1, GO_IDLE_ISSUED));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b0, ONES, ONES, ONES, ONES));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, 32'h0000_00AA, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, 32'h7FFF_FFFF, ONES, ONES, ONES));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, 32'hC000_0000, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, ONES, ONES, ONES, ONES));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, 32'hFFFF_0000, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, 32'h3FFF_FF00, '0, 32'h0040_0000));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, ONES, ONES, ONES, ONES));
		// Restart, fall back to eMMC, byte mode with a version 1 CSD, fail on CMD16
		bring_up_rows.push_back(row(ACT_START, 1'b1, ONES, ONES, ONES, ONES, 1'b1,
			GO_IDLE_ISSUED));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b0, 32'h0000_00AA, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b0, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, 32'h8000_0000, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, ONES, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, ONES, ONES, ONES, 32'hFF3F_FFFF));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b1, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_OUTCOME, 1'b0, '0, '0, '0, '0));
		bring_up_rows.push_back(row(ACT_START, 1'b0, ONES, '0, ONES, '0, 1'b1, GO_IDLE_ISSUED));

		// Hold reset, then release it on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (bring_up_rows[i]) begin
			offer(bring_up_rows[i].item, bring_up_rows[i].typed, bring_up_rows[i].result);
		end
		run_random(300);

		write_tries(12'd1);
		run_random(220);
		write_tries(12'd0);
		run_random(100);

		// Slow sender, eager receiver
		send_idle_pct = 82;
		recv_idle_pct = 11;
		write_tries(12'd4095);
		run_random(400);
		write_tries(12'd3);
		run_random(300);

		// No idling; one long receiver hold to back the block up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_tries(12'($urandom_range(4095, 1)));
		long_stall_request = 1'b1;
		run_random(300);
		write_tries(12'd2);
		run_random(300);

		drain();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
